[rtl/core/adsr_envelope_generator_top_defines.svh]
// Assertion macros for the ADSR envelope generator checker.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, silent during reset
`define ADSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, silent during reset
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/adsr_pkg.sv]
// Shared types and constants of the ADSR envelope generator.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package adsr_pkg;

  localparam int LVL_BITS        = 24;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int REG_IDX_BITS    = 3;

  // envelope phase codes as seen on the phase port
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // command codes; the fourth code acts as a plain sample
  localparam logic [1:0] CMD_PLAIN    = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PEAK    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_FLOOR   = 3'd6;

  // register reset values
  localparam logic                MODE_RST    = 1'b1;
  localparam logic [LVL_BITS-1:0] PEAK_RST    = 24'd15938355;
  localparam logic [LVL_BITS-1:0] SUSTAIN_RST = 24'd13421773;
  localparam logic [LVL_BITS-1:0] ATTACK_RST  = 24'd1774;
  localparam logic [LVL_BITS-1:0] DECAY_RST   = 24'd16764000;
  localparam logic [LVL_BITS-1:0] RELEASE_RST = 24'd16774000;
  localparam logic [LVL_BITS-1:0] FLOOR_RST   = 24'd16777;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_ENV_MUL,
    S_OUT_LOAD,
    S_OUT_MUL,
    S_DONE
  } seq_t;

endpackage

`default_nettype wire

[rtl/core/adsr_envelope_generator_top.sv]
// Each beat runs a step state, an envelope multiply when decay or release multiplies the level,
// an output load, an output multiply and a done state; the input stalls until back in idle.
// Both products run through one shared shift-add multiplier taking one level bit per cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst, synchronous): registers to defaults, level zero, phase idle, no result pending.
// Depends on adsr_pkg.
`default_nettype none

module adsr_envelope_generator_top
  import adsr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [REG_IDX_BITS-1:0]       wr_index,
  input  wire logic [LVL_BITS-1:0]           wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    command,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic [LVL_BITS-1:0]                level,
  output logic [2:0]                         phase
);

  localparam int MW    = ((SAMPLE_BITS > LVL_BITS) ? SAMPLE_BITS : LVL_BITS) + 1;
  localparam int CNT_W = $clog2(LVL_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LVL_BITS - 1);
  localparam logic signed [MW-1:0] SMAX =
    {{(MW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [MW-1:0] SMIN =
    {{(MW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // configuration registers
  logic                cfg_mode;
  logic [LVL_BITS-1:0] cfg_peak, cfg_sustain, cfg_attack, cfg_decay, cfg_release, cfg_floor;

  // sequencer and envelope state
  seq_t                state, state_next;
  logic [LVL_BITS-1:0] env_level, env_level_next;
  phase_t              env_phase, env_phase_next;

  // multiplier datapath
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_q_next;
  logic signed [MW-1:0]          mcand, mcand_next;
  logic [LVL_BITS-1:0]           mplier, mplier_next;
  logic signed [MW-1:0]          acc_hi, acc_hi_next;
  logic [CNT_W-1:0]              cnt, cnt_next;

  logic                          out_valid_next;
  logic signed [SAMPLE_BITS-1:0] sample_out_next;
  logic [LVL_BITS-1:0]           level_next;
  logic [2:0]                    phase_next;

  logic signed [MW:0]   mul_sum;
  logic signed [MW-1:0] acc_step;
  logic [LVL_BITS:0]    att_sum;
  logic [LVL_BITS-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode    <= MODE_RST;
      cfg_peak    <= PEAK_RST;
      cfg_sustain <= SUSTAIN_RST;
      cfg_attack  <= ATTACK_RST;
      cfg_decay   <= DECAY_RST;
      cfg_release <= RELEASE_RST;
      cfg_floor   <= FLOOR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:    cfg_mode    <= wr_data[0];
        REG_PEAK:    cfg_peak    <= wr_data;
        REG_SUSTAIN: cfg_sustain <= wr_data;
        REG_ATTACK:  cfg_attack  <= wr_data;
        REG_DECAY:   cfg_decay   <= wr_data;
        REG_RELEASE: cfg_release <= wr_data;
        REG_FLOOR:   cfg_floor   <= wr_data;
        default: ;
      endcase
    end
  end

  // one shift-add step: add the multiplicand when the low multiplier bit is set, shift right
  assign mul_sum  = {acc_hi[MW-1], acc_hi} + (mplier[0] ? {mcand[MW-1], mcand} : '0);
  assign acc_step = mul_sum[MW:1];
  assign scaled   = acc_step[LVL_BITS-1:0];
  assign att_sum  = {1'b0, env_level} + {1'b0, cfg_attack};

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    env_level_next  = env_level;
    env_phase_next  = env_phase;
    sample_q_next   = sample_q;
    mcand_next      = mcand;
    mplier_next     = mplier;
    acc_hi_next     = acc_hi;
    cnt_next        = cnt;
    out_valid_next  = out_valid && out_stall;
    sample_out_next = sample_out;
    level_next      = level;
    phase_next      = phase;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          sample_q_next = sample_in;
          if (command == CMD_NOTE_ON) begin
            env_phase_next = PH_ATTACK;
          end else if (command == CMD_NOTE_OFF &&
                       (env_phase == PH_ATTACK || env_phase == PH_DECAY ||
                        env_phase == PH_SUSTAIN)) begin
            env_phase_next = PH_RELEASE;
          end
          state_next = S_STEP;
        end
      end

      S_STEP: begin
        mplier_next = env_level;
        acc_hi_next = '0;
        cnt_next    = CNT_LAST;
        state_next  = S_OUT_LOAD;
        unique case (env_phase)
          PH_ATTACK: begin
            if (att_sum >= {1'b0, cfg_peak}) begin
              env_level_next = cfg_peak;
              env_phase_next = cfg_mode ? PH_DECAY : PH_RELEASE;
            end else begin
              env_level_next = att_sum[LVL_BITS-1:0];
            end
          end
          PH_DECAY: begin
            if (env_level > cfg_sustain) begin
              mcand_next = {{(MW - LVL_BITS){1'b0}}, cfg_decay};
              state_next = S_ENV_MUL;
            end else begin
              env_level_next = cfg_sustain;
              env_phase_next = PH_SUSTAIN;
            end
          end
          PH_SUSTAIN: begin
            env_level_next = cfg_sustain;
          end
          PH_RELEASE: begin
            // the one-shot rule tests the floor before the multiply
            if (cfg_mode || env_level >= cfg_floor) begin
              mcand_next = {{(MW - LVL_BITS){1'b0}}, cfg_release};
              state_next = S_ENV_MUL;
            end else begin
              env_level_next = '0;
              env_phase_next = PH_IDLE;
            end
          end
          default: begin
            env_level_next = '0;
            env_phase_next = PH_IDLE;
          end
        endcase
      end

      S_ENV_MUL: begin
        mplier_next = mplier >> 1;
        acc_hi_next = acc_step;
        cnt_next    = cnt - 1'b1;
        if (cnt == '0) begin
          state_next     = S_OUT_LOAD;
          env_level_next = scaled;
          if (env_phase == PH_DECAY) begin
            if (scaled <= cfg_sustain) begin
              env_level_next = cfg_sustain;
              env_phase_next = PH_SUSTAIN;
            end
          end else if (cfg_mode && scaled <= cfg_floor) begin
            env_level_next = '0;
            env_phase_next = PH_IDLE;
          end
        end
      end

      S_OUT_LOAD: begin
        mcand_next  = {{(MW - SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
        mplier_next = env_level;
        acc_hi_next = '0;
        cnt_next    = CNT_LAST;
        state_next  = S_OUT_MUL;
      end

      S_OUT_MUL: begin
        mplier_next = mplier >> 1;
        acc_hi_next = acc_step;
        cnt_next    = cnt - 1'b1;
        // the high half after the last step is the product floored by 2^24
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register frees up
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          if (acc_hi > SMAX) begin
            sample_out_next = SMAX[SAMPLE_BITS-1:0];
          end else if (acc_hi < SMIN) begin
            sample_out_next = SMIN[SAMPLE_BITS-1:0];
          end else begin
            sample_out_next = acc_hi[SAMPLE_BITS-1:0];
          end
          level_next = env_level;
          phase_next = env_phase;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      env_level <= '0;
      env_phase <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      env_level <= env_level_next;
      env_phase <= env_phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sample_q   <= sample_q_next;
    mcand      <= mcand_next;
    mplier     <= mplier_next;
    acc_hi     <= acc_hi_next;
    cnt        <= cnt_next;
    sample_out <= sample_out_next;
    level      <= level_next;
    phase      <= phase_next;
  end

endmodule

`default_nettype wire

[rtl/core/adsr_checker.sv]
// Port-level checker for the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg and adsr_envelope_generator_top_defines.svh.
`default_nettype none
`include "adsr_envelope_generator_top_defines.svh"

module adsr_checker
  import adsr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [SAMPLE_BITS-1:0] sample_out,
  input wire logic [LVL_BITS-1:0]           level,
  input wire logic [2:0]                    phase
);

  // an idle envelope always reports a zero level
  `ADSR_ASSERT_NOW(a_idle_level_zero, out_valid && phase == PH_IDLE, level == '0,
                   "idle with nonzero level")

  // a zero level silences the sample
  `ADSR_ASSERT_NOW(a_zero_level_mutes, out_valid && level == '0, sample_out == '0,
                   "zero level but sample passed")

  // a beat starts a multi-cycle sequence, so the input stalls right after it
  `ADSR_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall,
                    "input taken back to back")

  // a stalled result holds
  `ADSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(sample_out) && $stable(level) && $stable(phase),
                    "stalled result changed")

endmodule

bind adsr_envelope_generator_top adsr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_adsr_checker (.*);

`default_nettype wire

[test/adsr_envelope_generator_top_tb.sv]
// Self-checking testbench for adsr_envelope_generator_top: drives audio beats with note
// commands, predicts every result from its own envelope model and checks it field by field.
// Depends on adsr_pkg and the adsr_envelope_generator_top RTL.
module adsr_envelope_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adsr_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int MAX_WAIT = 13;
  localparam int MAX_REPORTS = 50;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct {
    logic [1:0]           cmd;
    logic signed [SB-1:0] smp;
  } beat_t;

  typedef struct {
    logic signed [SB-1:0] smp;
    logic [LVL_BITS-1:0]  lvl;
    phase_t               ph;
  } env_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [REG_IDX_BITS-1:0] wr_index = '0;
  logic [LVL_BITS-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] command = CMD_PLAIN;
  logic signed [SB-1:0] sample_in = '0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire signed [SB-1:0] sample_out;
  wire [LVL_BITS-1:0] level;
  wire [2:0] phase;

  adsr_envelope_generator_top #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .level(level), .phase(phase)
  );

  always #4 clk = ~clk;

  // envelope model: register copy and state
  logic                cfg_mode = MODE_RST;
  logic [LVL_BITS-1:0] cfg_peak = PEAK_RST;
  logic [LVL_BITS-1:0] cfg_sustain = SUSTAIN_RST;
  logic [LVL_BITS-1:0] cfg_attack = ATTACK_RST;
  logic [LVL_BITS-1:0] cfg_decay = DECAY_RST;
  logic [LVL_BITS-1:0] cfg_release = RELEASE_RST;
  logic [LVL_BITS-1:0] cfg_floor = FLOOR_RST;
  logic [LVL_BITS-1:0] env_lvl = '0;
  phase_t              env_ph = PH_IDLE;

  beat_t    pending_beats[$];
  env_out_t awaited_outputs[$];

  int unsigned beats_queued = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_used = 0;
  int unsigned errors = 0;
  int unsigned phase_hits[5];

  function automatic logic [LVL_BITS-1:0] scale_lvl(input logic [LVL_BITS-1:0] lvl,
                                                    input logic [LVL_BITS-1:0] coef);
    logic [2*LVL_BITS-1:0] p;
    p = (2*LVL_BITS)'(lvl) * (2*LVL_BITS)'(coef);
    return p[2*LVL_BITS-1:LVL_BITS];
  endfunction

  // apply the command, advance one step, and scale the sample by the new level
  function automatic env_out_t envelope_beat(input beat_t b);
    logic [LVL_BITS:0] nxt;
    longint prod;
    longint q;
    env_out_t r;
    if (b.cmd == CMD_NOTE_ON) begin
      env_ph = PH_ATTACK;
    end else if (b.cmd == CMD_NOTE_OFF &&
                 (env_ph == PH_ATTACK || env_ph == PH_DECAY || env_ph == PH_SUSTAIN)) begin
      env_ph = PH_RELEASE;
    end
    case (env_ph)
      PH_ATTACK: begin
        nxt = {1'b0, env_lvl} + {1'b0, cfg_attack};
        if (nxt >= {1'b0, cfg_peak}) begin
          env_lvl = cfg_peak;
          env_ph = cfg_mode ? PH_DECAY : PH_RELEASE;
        end else begin
          env_lvl = nxt[LVL_BITS-1:0];
        end
      end
      PH_DECAY: begin
        if (env_lvl > cfg_sustain) env_lvl = scale_lvl(env_lvl, cfg_decay);
        if (env_lvl <= cfg_sustain) begin
          env_lvl = cfg_sustain;
          env_ph = PH_SUSTAIN;
        end
      end
      PH_SUSTAIN: env_lvl = cfg_sustain;
      PH_RELEASE: begin
        if (cfg_mode) begin
          env_lvl = scale_lvl(env_lvl, cfg_release);
          if (env_lvl <= cfg_floor) begin
            env_lvl = '0;
            env_ph = PH_IDLE;
          end
        end else if (env_lvl >= cfg_floor) begin
          env_lvl = scale_lvl(env_lvl, cfg_release);
        end else begin
          env_lvl = '0;
          env_ph = PH_IDLE;
        end
      end
      default: begin
        env_lvl = '0;
        env_ph = PH_IDLE;
      end
    endcase
    // arithmetic shift floors negative products
    prod = longint'(b.smp) * longint'(env_lvl);
    q = prod >>> LVL_BITS;
    if (q > longint'(SMP_MAX)) q = longint'(SMP_MAX);
    if (q < longint'(SMP_MIN)) q = longint'(SMP_MIN);
    r.smp = q[SB-1:0];
    r.lvl = env_lvl;
    r.ph = env_ph;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      if (errors < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // sender
  int unsigned send_gap = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin
    bit offering;
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        b.cmd = command;
        b.smp = sample_in;
        awaited_outputs.push_back(envelope_beat(b));
        beats_sent++;
        offering = 1'b0;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          command <= b.cmd;
          sample_in <= b.smp;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // receiver
  int unsigned recv_gap = 0;
  int unsigned hold_off = 0;
  int unsigned hold_offs_done = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin
    env_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_off = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (phase < 5) phase_hits[phase]++;
        if (awaited_outputs.size() == 0) begin
          if (errors < MAX_REPORTS)
            $error("unexpected beat: sample_out %0d level %0d phase %0d",
                   sample_out, level, phase);
          errors++;
        end else begin
          want = awaited_outputs.pop_front();
          check_field("sample_out", longint'(want.smp), longint'(sample_out));
          check_field("level", longint'(want.lvl), longint'(level));
          check_field("phase", longint'(want.ph), longint'(phase));
        end
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid && recv_gap > 0) begin
        recv_gap--;
      end
      // hold off long enough for the block to back up into its input
      if (hold_offs_done < 2 && hold_off == 0 && pending_beats.size() > 20 &&
          results_seen >= 350 + 900 * hold_offs_done) begin
        hold_off = 300;
        hold_offs_done++;
      end
      if (hold_off > 0) hold_off--;
      out_stall <= (hold_off > 0) || (recv_gap > 0);
    end
  end

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return '1;
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] plain_cmd();
    return ($urandom_range(0, 15) == 0) ? CMD_SPARE : CMD_PLAIN;
  endfunction

  task automatic push_beat(input logic [1:0] cmd, input logic signed [SB-1:0] smp);
    beat_t b;
    b.cmd = cmd;
    b.smp = smp;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // mostly whole notes with random content, some stray commands and notes left open
  task automatic play_notes(input int unsigned count);
    int unsigned goal;
    int unsigned n;
    goal = beats_queued + count;
    while (beats_queued < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(2'($urandom_range(0, 3)), rand_sample());
      end else begin
        push_beat(CMD_NOTE_ON, rand_sample());
        n = $urandom_range(0, 40);
        repeat (n) push_beat(plain_cmd(), rand_sample());
        if ($urandom_range(0, 7) != 0) push_beat(CMD_NOTE_OFF, rand_sample());
        n = $urandom_range(0, 60);
        repeat (n) push_beat(plain_cmd(), rand_sample());
      end
    end
  endtask

  // wait until every queued beat has come back
  task automatic settle();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || awaited_outputs.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [LVL_BITS-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_MODE:    cfg_mode = data[0];
      REG_PEAK:    cfg_peak = data;
      REG_SUSTAIN: cfg_sustain = data;
      REG_ATTACK:  cfg_attack = data;
      REG_DECAY:   cfg_decay = data;
      REG_RELEASE: cfg_release = data;
      REG_FLOOR:   cfg_floor = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(input logic md, input logic [LVL_BITS-1:0] pk,
                                input logic [LVL_BITS-1:0] sus, input logic [LVL_BITS-1:0] att,
                                input logic [LVL_BITS-1:0] dec, input logic [LVL_BITS-1:0] rel,
                                input logic [LVL_BITS-1:0] flr);
    write_reg(REG_MODE, {{(LVL_BITS-1){1'b0}}, md});
    write_reg(REG_PEAK, pk);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_ATTACK, att);
    write_reg(REG_DECAY, dec);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_FLOOR, flr);
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // reset settings: short note cut by note off, note off while idle, unused command
    push_beat(CMD_NOTE_ON, SMP_MAX);
    push_beat(CMD_PLAIN, SMP_MIN);
    push_beat(CMD_PLAIN, '0);
    push_beat(CMD_SPARE, '1);
    push_beat(CMD_NOTE_OFF, 24'sd1);
    push_beat(CMD_NOTE_OFF, SMP_MAX);
    push_beat(CMD_PLAIN, SMP_MAX);
    settle();

    // writes to an unused index must leave every register alone
    write_reg(REG_UNUSED, '1);

    // fast ADSR with full-scale peak
    apply_settings(1'b1, 24'hFFFFFF, 24'h400000, 24'h200000, 24'hE00000, 24'hC00000,
                   24'h010000);
    push_beat(CMD_NOTE_ON, SMP_MAX);
    repeat (6) begin
      push_beat(CMD_PLAIN, SMP_MAX);
      push_beat(CMD_PLAIN, SMP_MIN);
    end
    push_beat(CMD_NOTE_OFF, SMP_MIN);
    push_beat(CMD_NOTE_OFF, SMP_MAX);
    push_beat(CMD_NOTE_ON, '1);
    push_beat(CMD_NOTE_OFF, 24'sd1);
    play_notes(220);
    settle();

    // AR one shot, attack done in one step
    apply_settings(1'b0, 24'h800000, 24'h400000, 24'hFFFFFF, 24'hE00000, 24'hE00000,
                   24'h004000);
    play_notes(220);
    settle();

    // attack that never ends unless the level already sits at the peak
    apply_settings(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF);
    play_notes(100);
    settle();

    // everything zero
    apply_settings(1'b0, '0, '0, '0, '0, '0, '0);
    play_notes(100);
    settle();

    // random settings; the last one fully random
    repeat (5) begin
      apply_settings(1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                     24'($urandom_range(24'h010000, 24'h800000)),
                     24'($urandom_range(24'hC00000, 24'hFFFFFF)),
                     24'($urandom_range(24'hC00000, 24'hFFFFFF)),
                     24'($urandom_range(0, 24'h010000)));
      play_notes(150);
      settle();
    end
    apply_settings(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom));
    play_notes(150);
    settle();

    repeat (60) @(posedge clk);
    $display("sent %0d beats under %0d register settings (%0d writes), checked %0d results",
             beats_sent, settings_used, reg_writes, results_seen);
    $display("results by phase: idle %0d, attack %0d, decay %0d, sustain %0d, release %0d",
             phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4]);
    if (errors == 0 && awaited_outputs.size() == 0) begin
      $display("adsr_envelope_generator_top_tb: done, clean");
    end else begin
      $display("adsr_envelope_generator_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results still awaited", awaited_outputs.size());
    $display("adsr_envelope_generator_top_tb: done, errors");
    $finish;
  end

endmodule
